// File: rtl/core/lsws_pkg.sv
// ----------------------------------------------------------------------------
// lsws_pkg: shared types and constants of the LIFO stack with search
// Command and status codes, response layout, cell control and scan status groups.
// ----------------------------------------------------------------------------
`default_nettype none

package lsws_pkg;

   localparam int DATA_W      = 32;
   localparam int POS_W       = 8;
   localparam int DEPTH_OUT_W = 8;
   localparam int STAT_W      = 2;
   localparam int CMD_W       = 2;
   localparam int RSP_PAD_W   = 5;
   localparam int RSP_W       = DATA_W + POS_W + STAT_W + 1 + DEPTH_OUT_W + RSP_PAD_W;
   localparam int GROUP_W     = 8;
   localparam int GROUP_OW    = 3;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
   localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_UNDERFLOW = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND  = 2'd3;

   localparam logic [DATA_W-1:0] DATA_NONE = '1;
   localparam logic [POS_W-1:0]  POS_NONE  = '1;

   typedef struct packed {
      logic push;
      logic pop;
      logic capture;
   } cell_ctrl_type;

   typedef struct packed {
      logic hit;
      logic found;
   } scan_stat_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0]   pad;
      logic [DEPTH_OUT_W-1:0] depth;
      logic                   is_empty;
      logic [STAT_W-1:0]      status;
      logic [POS_W-1:0]       position;
      logic [DATA_W-1:0]      data;
   } rsp_type;

endpackage

`default_nettype wire

// File: rtl/core/lsws_cell.sv
// ----------------------------------------------------------------------------
// lsws_cell: one stack slot
// Holds one word and its valid bit, shifts with its neighbors on push and pop,
// and registers a compare against the search key.
// ----------------------------------------------------------------------------
`default_nettype none

module lsws_cell
   import lsws_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire cell_ctrl_type  ctrl,
   input  wire  [DATA_W-1:0]   key,
   input  wire  [DATA_W-1:0]   above_data,
   input  wire                 above_valid,
   input  wire  [DATA_W-1:0]   below_data,
   input  wire                 below_valid,
   output logic [DATA_W-1:0]   data,
   output logic                valid,
   output logic                match
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              valid_ff;
   logic              valid_in;
   logic              match_ff;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.push) begin
         data_in  = above_data;
         valid_in = above_valid;
      end else if (ctrl.pop) begin
         data_in  = below_data;
         valid_in = below_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (ctrl.capture) begin
         match_ff <= valid_ff && (data_ff == key);
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data  = data_ff;
   assign valid = valid_ff;
   assign match = match_ff;

endmodule

`default_nettype wire

// File: rtl/core/lsws_scan.sv
// ----------------------------------------------------------------------------
// lsws_scan: nearest-match scanner
// Walks the registered match bits from the top, one group of cells per cycle,
// and reports the first match found.
// ----------------------------------------------------------------------------
`default_nettype none

module lsws_scan
   import lsws_pkg::*;
#(
   parameter int STACK_DEPTH = 128
)
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    start,
   input  wire  [STACK_DEPTH-1:0] match,
   output scan_stat_type          stat,
   output logic [POS_W-1:0]       position
);

   localparam int NG   = (STACK_DEPTH + GROUP_W - 1) / GROUP_W;
   localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
   localparam int PADW = NG * GROUP_W;

   logic [PADW-1:0]           match_pad;
   logic [GROUP_W-1:0]        slice;
   logic [GROUP_OW-1:0]       offset;
   logic [GW-1:0]             grp_ff;
   logic [GW-1:0]             grp_in;
   logic                      last;
   logic                      found;
   logic [POS_W+GW+GROUP_OW-1:0] pos_wide;

   assign match_pad = PADW'(match);
   assign slice     = match_pad[grp_ff*GROUP_W +: GROUP_W];
   assign last      = (grp_ff == GW'(NG - 1));
   assign found     = |slice;

   always_comb begin
      offset = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (slice[i]) begin
            offset = GROUP_OW'(i);
         end
      end
   end

   always_comb begin
      grp_in = grp_ff;
      if (start) begin
         grp_in = '0;
      end else if (!(found || last)) begin
         grp_in = grp_ff + GW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff <= '0;
      end else begin
         grp_ff <= grp_in;
      end
   end

   assign pos_wide   = {{POS_W{1'b0}}, grp_ff, offset};
   assign position   = pos_wide[POS_W-1:0];
   assign stat.hit   = found || last;
   assign stat.found = found;

endmodule

`default_nettype wire

// File: rtl/core/lifo_stack_with_search_core.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_core: bounded LIFO stack of words with search
// Shift-register stack built from a row of cells; top of stack sits in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : command words. req_tuser carries the command (push, pop, peek,
//            search), req_tdata the word to push or to search for.
//   rsp_*  : one response word per command with data, position, status,
//            empty flag and depth after the command.
// Operation: push, pop and peek answer on rsp in the cycle after acceptance
//   and can follow each other every cycle while rsp_tready takes each response.
//   A search first compares every cell in parallel into registered match bits,
//   then scans the match bits from the top, eight cells per cycle, and
//   req_tready stays low until it answers.
// Reset: clears the depth count and every cell's valid bit at once; stored
//   words are not cleared and need no clearing pass.
// Stall: a held response keeps req_tready low until rsp_tready takes it; a
//   command is accepted in the same cycle the pending response leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_search_core
   import lsws_pkg::*;
#(
   parameter int STACK_DEPTH = 128
)
(
   input  wire                clock,
   input  wire                reset,
   input  wire                req_tvalid,
   output logic               req_tready,
   input  wire  [DATA_W-1:0]  req_tdata,   // value
   input  wire  [CMD_W-1:0]   req_tuser,   // cmd
   output logic               rsp_tvalid,
   input  wire                rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata    // data, position, status, is_empty, depth, 0 pad
);

   localparam int CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type       state_ff;
   state_type       state_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_type         rsp_ff;
   rsp_type         rsp_in;

   logic            accept;
   logic            out_free;
   logic            full;
   logic            empty;
   cell_ctrl_type   ctrl;
   scan_stat_type   scan_stat;
   logic [POS_W-1:0] scan_pos;
   logic [CW+DEPTH_OUT_W-1:0] count_wide;

   logic [DATA_W-1:0]      cell_data  [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] cell_valid;
   logic [STACK_DEPTH-1:0] cell_match;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign full       = (count_ff == CW'(STACK_DEPTH));
   assign empty      = (count_ff == '0);

   assign ctrl.push    = accept && (req_tuser == CMD_PUSH) && !full;
   assign ctrl.pop     = accept && (req_tuser == CMD_POP) && !empty;
   assign ctrl.capture = accept && (req_tuser == CMD_SEARCH);

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] above_data;
      logic              above_valid;
      logic [DATA_W-1:0] below_data;
      logic              below_valid;

      if (i == 0) begin : g_top
         assign above_data  = req_tdata;
         assign above_valid = 1'b1;
      end else begin : g_mid
         assign above_data  = cell_data[i-1];
         assign above_valid = cell_valid[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below_data  = '0;
         assign below_valid = 1'b0;
      end else begin : g_up
         assign below_data  = cell_data[i+1];
         assign below_valid = cell_valid[i+1];
      end

      lsws_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .key         (req_tdata),
         .above_data  (above_data),
         .above_valid (above_valid),
         .below_data  (below_data),
         .below_valid (below_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i])
      );
   end

   lsws_scan #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .start    (ctrl.capture),
      .match    (cell_match),
      .stat     (scan_stat),
      .position (scan_pos)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_in       = rsp_ff;

      if (accept) begin
         if (req_tuser == CMD_SEARCH) begin
            state_in = ST_SCAN;
         end else begin
            rsp_valid_in    = 1'b1;
            rsp_in.data     = '0;
            rsp_in.position = '0;
            rsp_in.status   = STAT_OK;
            case (req_tuser)
               CMD_PUSH: begin
                  if (full) begin
                     rsp_in.status = STAT_OVERFLOW;
                  end else begin
                     count_in = count_ff + CW'(1);
                  end
               end
               CMD_POP: begin
                  if (empty) begin
                     rsp_in.data   = DATA_NONE;
                     rsp_in.status = STAT_UNDERFLOW;
                  end else begin
                     rsp_in.data = cell_data[0];
                     count_in    = count_ff - CW'(1);
                  end
               end
               CMD_PEEK: begin
                  if (empty) begin
                     rsp_in.data   = DATA_NONE;
                     rsp_in.status = STAT_UNDERFLOW;
                  end else begin
                     rsp_in.data = cell_data[0];
                  end
               end
               default: begin
                  rsp_in.data = '0;
               end
            endcase
         end
      end else if ((state_ff == ST_SCAN) && scan_stat.hit && out_free) begin
         state_in        = ST_IDLE;
         rsp_valid_in    = 1'b1;
         rsp_in.data     = '0;
         rsp_in.position = scan_stat.found ? scan_pos : POS_NONE;
         rsp_in.status   = scan_stat.found ? STAT_OK : STAT_NOTFOUND;
      end

      count_wide      = {{DEPTH_OUT_W{1'b0}}, count_in};
      rsp_in.pad      = '0;
      rsp_in.is_empty = (count_in == '0);
      rsp_in.depth    = count_wide[DEPTH_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

`default_nettype wire

// File: rtl/core/lsws_check.sv
// ----------------------------------------------------------------------------
// lsws_check: port-level checks of the LIFO stack with search
// Watches the response channel for held words and field consistency, and req_tready during a search.
// ----------------------------------------------------------------------------
`default_nettype none

module lsws_check
   import lsws_pkg::*;
(
   input  wire               clock,
   input  wire               reset,
   input  wire               req_tvalid,
   input  wire               req_tready,
   input  wire  [CMD_W-1:0]  req_tuser,
   input  wire               rsp_tvalid,
   input  wire               rsp_tready,
   input  wire  [RSP_W-1:0]  rsp_tdata
);

   rsp_type rsp;
   assign rsp = rsp_tdata;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status == STAT_UNDERFLOW) |->
         (rsp.data == DATA_NONE) && rsp.is_empty && (rsp.depth == '0))
      else $error("underflow word inconsistent");

   a_notfound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp.status == STAT_NOTFOUND) |->
         (rsp.position == POS_NONE) && (rsp.data == '0))
      else $error("not-found word inconsistent");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.is_empty |-> (rsp.depth == '0))
      else $error("empty flag with nonzero depth");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_SEARCH) |=> !req_tready)
      else $error("command accepted during search");

endmodule

bind lifo_stack_with_search_core lsws_check u_lsws_check (.*);

`default_nettype wire
